// ----- rtl/mmfe_pkg.sv -----
// Shared types, constants and helpers for the motor motion frame encoder.
// Holds the per-model limit table and the restoring divider step.
// No dependencies.
package mmfe_pkg;

  // Code resolution and model count
  localparam int CODE_BITS   = 16;
  localparam int MODEL_COUNT = 7;

  // Divisor and numerator widths: numerator is value span times full scale
  localparam int DIV_W = 32;
  localparam int NUM_W = DIV_W + CODE_BITS;

  // Divider lanes, one per scaled value
  localparam int LANES    = 5;
  localparam int LANE_POS = 0;
  localparam int LANE_VEL = 1;
  localparam int LANE_TRQ = 2;
  localparam int LANE_KP  = 3;
  localparam int LANE_KD  = 4;

  // Configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_POSITION_LIMIT = 1'd0;
  localparam logic [CFG_AW-1:0] REG_MOTION_TYPE    = 1'd1;

  // Reset values of the configuration registers
  localparam logic [30:0] POSITION_LIMIT_RESET = 31'd823550;
  localparam logic [4:0]  MOTION_TYPE_RESET    = 5'd1;

  // Word widths on the stream ports
  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 96;

  // Per-model limits in Q16.16
  typedef struct packed {
    logic [31:0] vel;
    logic [31:0] trq;
    logic [31:0] kp;
    logic [31:0] kd;
  } limits_t;

  // One divider stage: partial remainder, remaining numerator / quotient bits, divisor
  typedef struct packed {
    logic [DIV_W-1:0]     rem;
    logic [CODE_BITS-1:0] bits;
    logic [DIV_W-1:0]     den;
  } div_state_t;

  // Look up the limits of one motor model
  function automatic limits_t model_limits(input logic [2:0] model);
    limits_t l;
    case (model)
      3'd0:    l = '{vel: 32'd2162688, trq: 32'd917504,  kp: 32'd32768000,  kd: 32'd327680};
      3'd1:    l = '{vel: 32'd2883584, trq: 32'd1114112, kp: 32'd32768000,  kd: 32'd327680};
      3'd2:    l = '{vel: 32'd2883584, trq: 32'd1114112, kp: 32'd32768000,  kd: 32'd327680};
      3'd3:    l = '{vel: 32'd1310720, trq: 32'd3932160, kp: 32'd327680000, kd: 32'd6553600};
      3'd4:    l = '{vel: 32'd983040,  trq: 32'd7864320, kp: 32'd327680000, kd: 32'd6553600};
      3'd5:    l = '{vel: 32'd3276800, trq: 32'd360448,  kp: 32'd32768000,  kd: 32'd327680};
      3'd6:    l = '{vel: 32'd3276800, trq: 32'd2359296, kp: 32'd327680000, kd: 32'd6553600};
      default: l = '{vel: 32'd0,       trq: 32'd0,       kp: 32'd0,         kd: 32'd0};
    endcase
    return l;
  endfunction

  // One restoring division step: bring in the next numerator bit, subtract if it fits
  function automatic div_state_t div_step(input div_state_t s);
    logic [DIV_W:0] t;
    div_state_t     r;
    r = s;
    t = {s.rem, s.bits[CODE_BITS-1]};
    if (t >= {1'b0, s.den}) begin
      r.rem  = DIV_W'(t - {1'b0, s.den});
      r.bits = {s.bits[CODE_BITS-2:0], 1'b1};
    end else begin
      r.rem  = t[DIV_W-1:0];
      r.bits = {s.bits[CODE_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- rtl/mmfe_div_lane.sv -----
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on mmfe_pkg for widths, the stage type and the step function.
module mmfe_div_lane (
  input  logic                           clk,
  input  logic [mmfe_pkg::CODE_BITS-1:0] adv,
  input  logic [mmfe_pkg::NUM_W-1:0]     num,
  input  logic [mmfe_pkg::DIV_W-1:0]     den,
  output logic [mmfe_pkg::CODE_BITS-1:0] quo
);
  import mmfe_pkg::*;

  div_state_t st [CODE_BITS];
  div_state_t init;

  // Split the numerator: high part starts the remainder, low part shifts in
  always_comb begin
    init.rem  = num[NUM_W-1:CODE_BITS];
    init.bits = num[CODE_BITS-1:0];
    init.den  = den;
  end

  // Advance each stage when the pipeline control lets it load
  for (genvar k = 0; k < CODE_BITS; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          st[k] <= div_step(init);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          st[k] <= div_step(st[k-1]);
        end
      end
    end
  end

  assign quo = st[CODE_BITS-1].bits;

endmodule

// ----- rtl/motor_motion_frame_encoder_core.sv -----
// Top level of the motor motion frame encoder: validation, scaling and frame build.
// Depends on mmfe_pkg and mmfe_div_lane.
//
// Usage: one command word enters on the s_axis group (tvalid/tready/tdata) and one
// result word leaves on the m_axis group. A rejected command (unknown model, id
// outside 1..127, value outside its limits, zero position limit) comes out with
// ok low and every other field zero; a valid one carries the extended CAN id and
// the four payload codes.
// Pipeline: the check stage registers the word at the accepting edge, then it passes
// the numerator stage, one restoring divider stage per code bit in each of five
// parallel lanes, and the output register.
// Throughput: one word per cycle; every stage holds a valid bit and loads when it
// is empty or the stage after it moves, so a stalled receiver backs up the pipeline
// one stage at a time and input is still taken while bubbles remain.
// Configuration: cfg_we writes register cfg_addr (0 position limit, 1 motion type
// code) from cfg_wdata; write only while no word is in flight.
// Reset (rst, synchronous): clears all valid bits, holds s_axis_tready low and loads
// the register defaults (position limit 823550, motion type code 1).
module motor_motion_frame_encoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mmfe_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [30:0]                     cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // model[2:0], node_id[10:3], position_target[42:11], velocity_target[74:43],
  // torque_target[106:75], stiffness_gain[138:107], damping_gain[170:139], zeros above
  input  logic [mmfe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // ok[0], can_id[29:1], position_code[45:30], velocity_code[61:46],
  // stiffness_code[77:62], damping_code[93:78], zeros above
  output logic [mmfe_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import mmfe_pkg::*;

  // Stage map: 0 checks, 1 numerator, 2..CODE_BITS+1 divider, last is output
  localparam int STAGES   = CODE_BITS + 3;
  localparam int DIV_LAST = CODE_BITS + 1;
  localparam int OUT_ST   = CODE_BITS + 2;

  typedef struct packed {
    logic       ok;
    logic [7:0] id;
  } side_t;

  logic [30:0] position_limit;
  logic [4:0]  motion_type_code;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;
  side_t             side [DIV_LAST+1];

  logic [DIV_W-1:0] a_q [LANES];
  logic [DIV_W-1:0] m_q [LANES];
  logic [NUM_W-1:0] n_q [LANES];
  logic [DIV_W-1:0] d_q [LANES];
  logic [CODE_BITS-1:0] quo [LANES];

  logic [2:0]  in_model;
  logic [7:0]  in_id;
  logic [31:0] in_val [LANES];
  limits_t     lim;
  logic [DIV_W-1:0] m_c [LANES];
  logic [DIV_W-1:0] a_c [LANES];
  logic        ok_c;

  logic [28:0] can_id;
  logic [OUT_DATA_W-1:0] out_word;

  // Value within [-m, m]
  function automatic logic in_bipolar(input logic [31:0] v, input logic [31:0] m);
    logic signed [32:0] sv;
    logic signed [32:0] sm;
    sv = {v[31], v};
    sm = {1'b0, m};
    return (sv <= sm) && (sv >= -sm);
  endfunction

  // Value within [0, m]
  function automatic logic in_unipolar(input logic [31:0] v, input logic [31:0] m);
    return !v[31] && ({1'b0, v} <= {1'b0, m});
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position_limit   <= POSITION_LIMIT_RESET;
      motion_type_code <= MOTION_TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POSITION_LIMIT: position_limit   <= cfg_wdata;
        REG_MOTION_TYPE:    motion_type_code <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Stage load enables: a stage loads when empty or when its successor moves
  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || m_axis_tready;
    for (int s = STAGES - 2; s >= 0; s--) begin
      adv[s] = !vld[s] || adv[s+1];
    end
  end

  assign s_axis_tready = adv[0] && !rst;

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < STAGES; s++) begin
        if (adv[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // Unpack the command and check it against its model's limits
  always_comb begin
    in_model           = s_axis_tdata[2:0];
    in_id              = s_axis_tdata[10:3];
    in_val[LANE_POS]   = s_axis_tdata[42:11];
    in_val[LANE_VEL]   = s_axis_tdata[74:43];
    in_val[LANE_TRQ]   = s_axis_tdata[106:75];
    in_val[LANE_KP]    = s_axis_tdata[138:107];
    in_val[LANE_KD]    = s_axis_tdata[170:139];
    lim                = model_limits(in_model);
    m_c[LANE_POS]      = {1'b0, position_limit};
    m_c[LANE_VEL]      = lim.vel;
    m_c[LANE_TRQ]      = lim.trq;
    m_c[LANE_KP]       = lim.kp;
    m_c[LANE_KD]       = lim.kd;
    ok_c = ({1'b0, in_model} < 4'(MODEL_COUNT))
        && (in_id != 8'd0) && !in_id[7]
        && (position_limit != 31'd0)
        && in_bipolar(in_val[LANE_POS], m_c[LANE_POS])
        && in_bipolar(in_val[LANE_VEL], m_c[LANE_VEL])
        && in_bipolar(in_val[LANE_TRQ], m_c[LANE_TRQ])
        && in_unipolar(in_val[LANE_KP], m_c[LANE_KP])
        && in_unipolar(in_val[LANE_KD], m_c[LANE_KD]);
    // Span from the range bottom: v + m for bipolar, 2v for unipolar
    a_c[LANE_POS] = in_val[LANE_POS] + m_c[LANE_POS];
    a_c[LANE_VEL] = in_val[LANE_VEL] + m_c[LANE_VEL];
    a_c[LANE_TRQ] = in_val[LANE_TRQ] + m_c[LANE_TRQ];
    a_c[LANE_KP]  = {in_val[LANE_KP][30:0], 1'b0};
    a_c[LANE_KD]  = {in_val[LANE_KD][30:0], 1'b0};
  end

  // Stage 0: register spans and range bounds
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int l = 0; l < LANES; l++) begin
        a_q[l] <= a_c[l];
        m_q[l] <= m_c[l];
      end
    end
  end

  // Stage 1: numerator span * full scale + m (shift and subtract), divisor 2m
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int l = 0; l < LANES; l++) begin
        n_q[l] <= {a_q[l], {CODE_BITS{1'b0}}} - NUM_W'(a_q[l]) + NUM_W'(m_q[l]);
        d_q[l] <= {m_q[l][DIV_W-2:0], 1'b0};
      end
    end
  end

  // Register the check result, then carry the sideband through the numerator and divider stages
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side[0] <= '{ok: ok_c, id: in_id};
    end
    for (int s = 1; s <= DIV_LAST; s++) begin
      if (adv[s]) begin
        side[s] <= side[s-1];
      end
    end
  end

  // Five divider lanes share the stage enables
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mmfe_div_lane u_div (
      .clk (clk),
      .adv (adv[DIV_LAST:2]),
      .num (n_q[l]),
      .den (d_q[l]),
      .quo (quo[l])
    );
  end

  // Build the frame; drop everything but ok on a rejected command
  always_comb begin
    can_id   = {motion_type_code, 16'(quo[LANE_TRQ]), side[DIV_LAST].id};
    out_word = '0;
    if (side[DIV_LAST].ok) begin
      out_word[0]     = 1'b1;
      out_word[29:1]  = can_id;
      out_word[45:30] = 16'(quo[LANE_POS]);
      out_word[61:46] = 16'(quo[LANE_VEL]);
      out_word[77:62] = 16'(quo[LANE_KP]);
      out_word[93:78] = 16'(quo[LANE_KD]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv[OUT_ST]) begin
      m_axis_tdata <= out_word;
    end
  end

  assign m_axis_tvalid = vld[OUT_ST];

endmodule

// ----- bench/motor_motion_frame_encoder_core_tb.sv -----
// Self-checking bench for motor_motion_frame_encoder_core: a directed table, then random
// commands over several register settings, each result word checked against its table frame or a predictor.
// Depends on mmfe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module motor_motion_frame_encoder_core_tb;
  import mmfe_pkg::*;

  localparam int      PIPE_LATENCY = CODE_BITS + 3;
  localparam int      IDLE_PCT     = 6;
  localparam int      CYCLE_LIMIT  = 300000;
  localparam int      PHASES       = 10;
  localparam int      PHASE_CMDS   = 113;
  localparam longint  FULL_SCALE   = (64'sd1 <<< CODE_BITS) - 1;
  localparam longint  Q_MAX        = 64'sd2147483647;

  // One command word, first field in the lowest bits
  typedef struct packed {
    logic [31:0] damping_gain;
    logic [31:0] stiffness_gain;
    logic [31:0] torque_target;
    logic [31:0] velocity_target;
    logic [31:0] position_target;
    logic [7:0]  node_id;
    logic [2:0]  model;
  } motion_cmd_t;

  // One result word, ok in bit 0
  typedef struct packed {
    logic [15:0] damping_code;
    logic [15:0] stiffness_code;
    logic [15:0] velocity_code;
    logic [15:0] position_code;
    logic [28:0] can_id;
    logic        ok;
  } motion_frame_t;

  typedef struct {
    longint vel;
    longint trq;
    longint kp;
    longint kd;
  } axis_limits_t;

  typedef enum {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    motion_cmd_t           cmd;
    bit                    typed;
    motion_frame_t         want;
    logic [CFG_AW-1:0]     idx;
    logic [30:0]           val;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr = '0;
  logic [30:0]           cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // model, node_id, position, velocity, torque, stiffness, damping, zeros
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // ok, can_id, position, velocity, stiffness, damping codes, zeros
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Register copies used by the predictor
  logic [30:0]           pos_limit = POSITION_LIMIT_RESET;
  logic [4:0]            type_code = MOTION_TYPE_RESET;

  motion_frame_t         frames_due[$];
  script_row_t           script[$];
  int                    frame_errors = 0;
  int                    cycles = 0;
  bit                    quiet = 1'b0;

  motor_motion_frame_encoder_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Velocity, torque, stiffness and damping bounds per motor model, Q16.16
  function automatic axis_limits_t limits_of(logic [2:0] model);
    case (model)
      3'd0:    return '{2162688, 917504,  32768000,  327680};
      3'd1:    return '{2883584, 1114112, 32768000,  327680};
      3'd2:    return '{2883584, 1114112, 32768000,  327680};
      3'd3:    return '{1310720, 3932160, 327680000, 6553600};
      3'd4:    return '{983040,  7864320, 327680000, 6553600};
      3'd5:    return '{3276800, 360448,  32768000,  327680};
      3'd6:    return '{3276800, 2359296, 327680000, 6553600};
      default: return '{0, 0, 0, 0};
    endcase
  endfunction

  // Round-half-up map of [-m, m] and of [0, m] onto the code range
  function automatic logic [15:0] bipolar_code(longint v, longint m);
    return 16'(((v + m) * FULL_SCALE + m) / (2 * m));
  endfunction

  function automatic logic [15:0] unipolar_code(longint v, longint m);
    return 16'((2 * v * FULL_SCALE + m) / (2 * m));
  endfunction

  // Validate one command and build its frame; a rejected command gives all zeros
  function automatic motion_frame_t encode_frame(motion_cmd_t c);
    motion_frame_t f;
    axis_limits_t  lim;
    longint        pl, pos, vel, trq, kp, kd;
    f   = '0;
    pl  = longint'(pos_limit);
    pos = longint'($signed(c.position_target));
    vel = longint'($signed(c.velocity_target));
    trq = longint'($signed(c.torque_target));
    kp  = longint'($signed(c.stiffness_gain));
    kd  = longint'($signed(c.damping_gain));
    if (c.model >= MODEL_COUNT || c.node_id == 8'd0 || c.node_id > 8'd127 || pl == 0)
      return f;
    lim = limits_of(c.model);
    if (pos < -pl || pos > pl || vel < -lim.vel || vel > lim.vel ||
        trq < -lim.trq || trq > lim.trq || kp < 0 || kp > lim.kp || kd < 0 || kd > lim.kd)
      return f;
    f.ok             = 1'b1;
    f.can_id         = {type_code, bipolar_code(trq, lim.trq), c.node_id};
    f.position_code  = bipolar_code(pos, pl);
    f.velocity_code  = bipolar_code(vel, lim.vel);
    f.stiffness_code = unipolar_code(kp, lim.kp);
    f.damping_code   = unipolar_code(kd, lim.kd);
    return f;
  endfunction

  // In-range value, biased toward the bounds and zero
  function automatic logic [31:0] pick_in(longint m, bit bipolar);
    longint lo, near;
    lo   = bipolar ? -m : 0;
    near = longint'($urandom_range(m < 4 ? 32'(m) : 32'd4));
    case ($urandom_range(9))
      0:       return 32'(lo);
      1:       return 32'(m);
      2:       return 32'd0;
      3:       return 32'(m - near);
      4:       return 32'(lo + near);
      default: return 32'(longint'($urandom_range(32'(m - lo))) + lo);
    endcase
  endfunction

  // Value just past a bound, or a random one outside the range
  function automatic logic [31:0] pick_out(longint m, bit bipolar);
    longint lo, v;
    lo = bipolar ? -m : 0;
    case ($urandom_range(3))
      0:       v = lo - 1;
      1:       v = (m < Q_MAX) ? m + 1 : lo - 1;
      default: begin
        v = longint'($signed($urandom));
        if (v >= lo && v <= m) v = lo - 1;
      end
    endcase
    return 32'(v);
  endfunction

  // Mostly well-formed commands, some with one bad field, the rest pure noise
  function automatic motion_cmd_t random_cmd();
    motion_cmd_t  c;
    axis_limits_t lim;
    int           r;
    r = $urandom_range(99);
    if (r >= 75) begin
      c = {$urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom), 3'($urandom)};
      return c;
    end
    c.model           = 3'($urandom_range(MODEL_COUNT - 1));
    c.node_id         = 8'($urandom_range(127, 1));
    lim               = limits_of(c.model);
    c.position_target = pick_in(longint'(pos_limit), 1'b1);
    c.velocity_target = pick_in(lim.vel, 1'b1);
    c.torque_target   = pick_in(lim.trq, 1'b1);
    c.stiffness_gain  = pick_in(lim.kp, 1'b0);
    c.damping_gain    = pick_in(lim.kd, 1'b0);
    if (r < 15) begin
      case ($urandom_range(6))
        0: c.model = 3'd7;
        1: c.node_id = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 128));
        2: c.position_target = pick_out(longint'(pos_limit), 1'b1);
        3: c.velocity_target = pick_out(lim.vel, 1'b1);
        4: c.torque_target = pick_out(lim.trq, 1'b1);
        5: c.stiffness_gain = pick_out(lim.kp, 1'b0);
        default: c.damping_gain = pick_out(lim.kd, 1'b0);
      endcase
    end
    return c;
  endfunction

  function automatic motion_cmd_t cmd_of(int model, int id, longint pos, longint vel,
                                         longint trq, longint kp, longint kd);
    motion_cmd_t c;
    c.model           = 3'(model);
    c.node_id         = 8'(id);
    c.position_target = 32'(pos);
    c.velocity_target = 32'(vel);
    c.torque_target   = 32'(trq);
    c.stiffness_gain  = 32'(kp);
    c.damping_gain    = 32'(kd);
    return c;
  endfunction

  function automatic motion_frame_t frame_of(int tc, int tq, int id, int pc, int vc,
                                             int kc, int dc);
    motion_frame_t f;
    f.ok             = 1'b1;
    f.can_id         = {5'(tc), 16'(tq), 8'(id)};
    f.position_code  = 16'(pc);
    f.velocity_code  = 16'(vc);
    f.stiffness_code = 16'(kc);
    f.damping_code   = 16'(dc);
    return f;
  endfunction

  task automatic add_cmd(motion_cmd_t c, bit typed, motion_frame_t want);
    script_row_t r;
    r.kind  = ROW_CMD;
    r.cmd   = c;
    r.typed = typed;
    r.want  = want;
    r.idx   = '0;
    r.val   = '0;
    script.push_back(r);
  endtask

  task automatic add_cfg(logic [CFG_AW-1:0] idx, logic [30:0] val);
    script_row_t r;
    r.kind  = ROW_CFG;
    r.cmd   = '0;
    r.typed = 1'b0;
    r.want  = '0;
    r.idx   = idx;
    r.val   = val;
    script.push_back(r);
  endtask

  // Offer one command word, idling at random first; record its frame on acceptance
  task automatic send_cmd(motion_cmd_t c, motion_frame_t want);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(c);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    frames_due.push_back(want);
  endtask

  // Hold off input until every frame is back and the pipe is empty
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_POSITION_LIMIT) pos_limit = val;
    else type_code = val[4:0];
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      frame_errors++;
    end
  endtask

  // Receiver stalls at random except in the quiet stretch
  always @(posedge clk) m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);

  // Check each result word against the oldest outstanding frame
  always @(posedge clk) begin
    motion_frame_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(motion_frame_t)-1:0];
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual 0x%0h", $time, m_axis_tdata);
        frame_errors++;
      end else begin
        want = frames_due.pop_front();
        check_field("ok", 32'(want.ok), 32'(got.ok));
        check_field("can_id", 32'(want.can_id), 32'(got.can_id));
        check_field("position_code", 32'(want.position_code), 32'(got.position_code));
        check_field("velocity_code", 32'(want.velocity_code), 32'(got.velocity_code));
        check_field("stiffness_code", 32'(want.stiffness_code), 32'(got.stiffness_code));
        check_field("damping_code", 32'(want.damping_code), 32'(got.damping_code));
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    motion_cmd_t c;
    // Directed rows under the reset settings: position limit 823550, type code 1
    add_cmd(cmd_of(7, 1, 0, 0, 0, 0, 0), 1, '0);
    add_cmd(cmd_of(0, 0, 0, 0, 0, 0, 0), 1, '0);
    add_cmd(cmd_of(0, 128, 0, 0, 0, 0, 0), 1, '0);
    add_cmd(cmd_of(0, 255, 0, 0, 0, 0, 0), 1, '0);
    add_cmd(cmd_of(0, 1, -823550, -2162688, -917504, 0, 0), 1, frame_of(1, 0, 1, 0, 0, 0, 0));
    add_cmd(cmd_of(0, 127, 823550, 2162688, 917504, 32768000, 327680), 1,
            frame_of(1, 65535, 127, 65535, 65535, 65535, 65535));
    add_cmd(cmd_of(3, 5, 0, 0, 0, 0, 0), 1, frame_of(1, 32768, 5, 32768, 32768, 0, 0));
    // One bound of each field exceeded by one, and the far ends of the position field
    add_cmd(cmd_of(0, 1, 823551, 0, 0, 0, 0), 1, '0);
    add_cmd(cmd_of(4, 9, 0, 983041, 0, 0, 0), 1, '0);
    add_cmd(cmd_of(5, 9, 0, 0, -360449, 0, 0), 1, '0);
    add_cmd(cmd_of(1, 9, 0, 0, 0, -1, 0), 1, '0);
    add_cmd(cmd_of(6, 9, 0, 0, 0, 0, 6553601), 1, '0);
    add_cmd(cmd_of(2, 9, -64'sd2147483648, 0, 0, 0, 0), 1, '0);
    add_cmd(cmd_of(2, 9, 2147483647, 0, 0, 0, 0), 1, '0);
    // Values on models 1, 2, 4, 5 and 6, some at their bounds, left to the predictor
    add_cmd(cmd_of(1, 42, 12345, -100000, 500000, 1000000, 200000), 0, '0);
    add_cmd(cmd_of(2, 100, -400000, 2883584, -1114112, 32768000, 1), 0, '0);
    add_cmd(cmd_of(5, 77, 1, -1, 360448, 16384000, 163840), 0, '0);
    add_cmd(cmd_of(6, 3, -1, 3276800, 1, 327680000, 6553600), 0, '0);
    add_cmd(cmd_of(4, 64, 700000, -983040, 7864320, 123456789, 3000000), 0, '0);
    // Zero position limit rejects everything
    add_cfg(REG_POSITION_LIMIT, 31'd0);
    add_cmd(cmd_of(0, 1, 0, 0, 0, 0, 0), 1, '0);
    // Widest position range and the top type code
    add_cfg(REG_POSITION_LIMIT, 31'h7FFFFFFF);
    add_cfg(REG_MOTION_TYPE, 31'd31);
    add_cmd(cmd_of(4, 127, -2147483647, -983040, -7864320, 0, 0), 1,
            frame_of(31, 0, 127, 0, 0, 0, 0));
    add_cmd(cmd_of(4, 127, 2147483647, 983040, 7864320, 327680000, 6553600), 1,
            frame_of(31, 65535, 127, 65535, 65535, 65535, 65535));
    add_cmd(cmd_of(3, 1, -64'sd2147483648, 0, 0, 0, 0), 1, '0);
    // Narrowest position range and type code zero
    add_cfg(REG_POSITION_LIMIT, 31'd1);
    add_cfg(REG_MOTION_TYPE, 31'd0);
    add_cmd(cmd_of(0, 1, -1, 0, 0, 0, 0), 0, '0);
    add_cmd(cmd_of(0, 1, 1, 0, 0, 0, 0), 0, '0);

    // Hold reset, then walk the table
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        drain_pipe();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_cmd(script[i].cmd,
                 script[i].typed ? script[i].want : encode_frame(script[i].cmd));
      end
    end

    // Random commands over a sweep of register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_pipe();
      quiet = (ph == 6);
      case (ph)
        0: begin
          write_reg(REG_POSITION_LIMIT, POSITION_LIMIT_RESET);
          write_reg(REG_MOTION_TYPE, 31'(MOTION_TYPE_RESET));
        end
        1: begin
          write_reg(REG_POSITION_LIMIT, 31'h7FFFFFFF);
          write_reg(REG_MOTION_TYPE, 31'd31);
        end
        2: begin
          write_reg(REG_POSITION_LIMIT, 31'd1);
          write_reg(REG_MOTION_TYPE, 31'd0);
        end
        3: begin
          write_reg(REG_POSITION_LIMIT, 31'd0);
          write_reg(REG_MOTION_TYPE, 31'($urandom_range(31)));
        end
        4: begin
          write_reg(REG_POSITION_LIMIT, 31'd65536);
          write_reg(REG_MOTION_TYPE, 31'($urandom_range(31)));
        end
        default: begin
          write_reg(REG_POSITION_LIMIT, $urandom_range(1) ? 31'($urandom_range(2000000, 1))
                                                          : 31'($urandom_range(32'h7FFFFFFF, 1)));
          write_reg(REG_MOTION_TYPE, 31'($urandom_range(31)));
        end
      endcase
      for (int n = 0; n < PHASE_CMDS; n++) begin
        c = random_cmd();
        send_cmd(c, encode_frame(c));
      end
    end

    // Let the last frames out, then report
    drain_pipe();
    quiet = 1'b0;
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (frame_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mmfe_pkg.sv
rtl/mmfe_div_lane.sv
rtl/motor_motion_frame_encoder_core.sv
bench/motor_motion_frame_encoder_core_tb.sv
